// File: rtl/imu_fs_pkg.sv
// Shared constants, widths and controller/datapath interface types for the IMU frame scaler.
`default_nettype none

package imu_fs_pkg;

    // Burst length limit for the temperature average
    localparam int MAX_FRAMES = 128;

    // Frame counter must hold MAX_FRAMES itself
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    // Signed sum of up to MAX_FRAMES temperature words
    localparam int ACC_W  = $clog2(MAX_FRAMES) + 16;
    // Magnitude of sum times 24-bit gain
    localparam int NUM_W  = ACC_W + 24;
    // Dividend after folding the divide by 256 into a shift
    localparam int QW     = NUM_W - 7;
    // Signed quotient plus offset
    localparam int TSUM_W = QW + 2;
    // Divider step counter
    localparam int STEP_W = $clog2(QW);

    // g in m/s2, unsigned Q4.24
    localparam logic [27:0] G_Q24 = 28'd164528285;
    // 250 deg/s over 32768 LSB, in Q16.16
    localparam logic signed [10:0] GYRO_LSB = 11'sd500;

    // Configuration register indexes
    localparam logic [1:0] CFG_ACCEL_SEL = 2'd0;
    localparam logic [1:0] CFG_GYRO_SEL  = 2'd1;
    localparam logic [1:0] CFG_TEMP_GAIN = 2'd2;
    localparam logic [1:0] CFG_TEMP_BIAS = 2'd3;

    // Configuration reset values
    localparam logic [23:0]        TEMP_GAIN_RST = 24'd51338;
    localparam logic signed [24:0] TEMP_BIAS_RST = 25'sd1638400;

    // Temperature saturation limits
    localparam logic signed [TSUM_W-1:0] TMP_MAX = TSUM_W'(8388607);
    localparam logic signed [TSUM_W-1:0] TMP_MIN = -TSUM_W'(8388608);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic mul;
        logic rnd;
        logic tadj;
        logic fin;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/imu_fs_div.sv
// Restoring divider, one quotient bit per cycle, for the burst temperature average.
`default_nettype none

module imu_fs_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [imu_fs_pkg::QW-1:0]   i_dividend,
    input  wire logic [imu_fs_pkg::CNT_W-1:0] i_divisor,
    output logic      [imu_fs_pkg::QW-1:0]   o_quotient,
    output logic                             o_done
);

    logic                              r_busy;
    logic                              r_done;
    logic [imu_fs_pkg::STEP_W-1:0]     r_step;
    logic [imu_fs_pkg::QW-1:0]         r_quo;
    logic [imu_fs_pkg::CNT_W-1:0]      r_rem;
    logic [imu_fs_pkg::CNT_W-1:0]      r_den;

    logic [imu_fs_pkg::CNT_W:0]        trial;
    logic [imu_fs_pkg::CNT_W:0]        diff;
    logic                              ge;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        trial = {r_rem, r_quo[imu_fs_pkg::QW-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    // Sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= imu_fs_pkg::STEP_W'(imu_fs_pkg::QW - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    // Quotient and remainder shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[imu_fs_pkg::QW-2:0], ge};
            r_rem <= ge ? diff[imu_fs_pkg::CNT_W-1:0] : trial[imu_fs_pkg::CNT_W-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

    // A new division never starts over one in flight
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    // Done follows the final step
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == '0 && !i_start) |=> (o_done && !r_busy))
        else $error("divider done missing after final step");

endmodule

`default_nettype wire

// File: rtl/imu_fs_datapath.sv
// Datapath: configuration registers, axis scaling, temperature sum and average, output register.
`default_nettype none

module imu_fs_datapath (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire imu_fs_pkg::t_cmd         i_cmd,
    output imu_fs_pkg::t_sts              o_sts,
    input  wire logic                     i_cfg_we,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [24:0]              i_cfg_data,
    input  wire logic signed [15:0]       i_accel_x_raw,
    input  wire logic signed [15:0]       i_accel_y_raw,
    input  wire logic signed [15:0]       i_accel_z_raw,
    input  wire logic signed [15:0]       i_temp_raw,
    input  wire logic signed [15:0]       i_gyro_x_raw,
    input  wire logic signed [15:0]       i_gyro_y_raw,
    input  wire logic signed [15:0]       i_gyro_z_raw,
    input  wire logic                     i_last_frame,
    input  wire logic                     i_out_stall,
    output logic                          o_out_valid,
    output logic signed [24:0]            o_accel_x_out,
    output logic signed [24:0]            o_accel_y_out,
    output logic signed [24:0]            o_accel_z_out,
    output logic signed [27:0]            o_gyro_x_out,
    output logic signed [27:0]            o_gyro_y_out,
    output logic signed [27:0]            o_gyro_z_out,
    output logic signed [23:0]            o_temperature_out,
    output logic                          o_temp_valid,
    output logic [7:0]                    o_frames_in_burst,
    output logic                          o_last_out
);

    // Configuration
    logic [1:0]                           r_accel_sel;
    logic [1:0]                           r_gyro_sel;
    logic [23:0]                          r_gain;
    logic signed [24:0]                   r_offset;

    // Captured input word
    logic signed [15:0]                   r_ax, r_ay, r_az, r_temp;
    logic signed [15:0]                   r_gx, r_gy, r_gz;
    logic                                 r_last;

    // Axis stages
    logic [43:0]                          r_amag [3];
    logic                                 r_aneg [3];
    logic signed [24:0]                   r_aout [3];
    logic signed [27:0]                   r_gyro [3];

    // Burst temperature state
    logic signed [imu_fs_pkg::ACC_W-1:0]  r_acc;
    logic [imu_fs_pkg::CNT_W-1:0]         r_cnt;
    logic                                 r_tneg;
    logic [imu_fs_pkg::NUM_W-1:0]         r_tprod;
    logic [7:0]                           r_frames;
    logic signed [23:0]                   r_temp_out;

    // Output register
    logic                                 r_ovalid;
    logic signed [24:0]                   r_o_ax, r_o_ay, r_o_az;
    logic signed [27:0]                   r_o_gx, r_o_gy, r_o_gz;
    logic signed [23:0]                   r_o_temp;
    logic                                 r_o_tvalid;
    logic [7:0]                           r_o_frames;
    logic                                 r_o_last;

    // Combinational terms
    logic signed [15:0]                   a_val [3];
    logic [15:0]                          a_mag [3];
    logic [43:0]                          a_prod [3];
    logic [46:0]                          a_sh [3];
    logic [46:0]                          a_rnd [3];
    logic [24:0]                          a_q [3];
    logic signed [15:0]                   g_val [3];
    logic signed [26:0]                   g_prod [3];
    logic [imu_fs_pkg::ACC_W-1:0]         acc_mag;
    logic [imu_fs_pkg::NUM_W:0]           t_num;
    logic [imu_fs_pkg::QW-1:0]            div_quo;
    logic                                 div_done;
    logic signed [imu_fs_pkg::QW:0]       t_sq;
    logic signed [imu_fs_pkg::TSUM_W-1:0] t_sum;
    logic signed [imu_fs_pkg::TSUM_W-1:0] t_sat;
    logic [imu_fs_pkg::CNT_W+7:0]         cnt_ext;
    logic                                 out_free;

    // Negate with -32768 saturating to +32767
    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
        neg_sat = (v == 16'sh8000) ? 16'sh7FFF : -v;
    endfunction

    // Axis magnitudes, products and rounding
    always_comb begin
        a_val[0] = r_ax;
        a_val[1] = neg_sat(r_ay);
        a_val[2] = neg_sat(r_az);
        g_val[0] = r_gx;
        g_val[1] = neg_sat(r_gy);
        g_val[2] = neg_sat(r_gz);
        for (int i = 0; i < 3; i++) begin
            a_mag[i]  = a_val[i][15] ? $unsigned(-a_val[i]) : $unsigned(a_val[i]);
            a_prod[i] = a_mag[i] * imu_fs_pkg::G_Q24;
            a_sh[i]   = {3'b000, r_amag[i]} << r_accel_sel;
            a_rnd[i]  = a_sh[i] + 47'd2097152;
            a_q[i]    = a_rnd[i][46:22];
            g_prod[i] = g_val[i] * imu_fs_pkg::GYRO_LSB;
        end
    end

    // Temperature magnitude, dividend and final offset with saturation
    always_comb begin
        acc_mag = r_acc[imu_fs_pkg::ACC_W-1] ? $unsigned(-r_acc) : $unsigned(r_acc);
        t_num   = {1'b0, r_tprod} + (imu_fs_pkg::NUM_W + 1)'({r_cnt, 7'b0});
        t_sq    = r_tneg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        t_sum   = imu_fs_pkg::TSUM_W'(t_sq) + imu_fs_pkg::TSUM_W'(r_offset);
        if (t_sum > imu_fs_pkg::TMP_MAX) begin
            t_sat = imu_fs_pkg::TMP_MAX;
        end else if (t_sum < imu_fs_pkg::TMP_MIN) begin
            t_sat = imu_fs_pkg::TMP_MIN;
        end else begin
            t_sat = t_sum;
        end
        cnt_ext = {8'd0, r_cnt};
    end

    imu_fs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.tadj),
        .i_dividend (t_num[imu_fs_pkg::NUM_W:8]),
        .i_divisor  (r_cnt),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_sel <= 2'd0;
            r_gyro_sel  <= 2'd0;
            r_gain      <= imu_fs_pkg::TEMP_GAIN_RST;
            r_offset    <= imu_fs_pkg::TEMP_BIAS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                imu_fs_pkg::CFG_ACCEL_SEL: r_accel_sel <= i_cfg_data[1:0];
                imu_fs_pkg::CFG_GYRO_SEL:  r_gyro_sel  <= i_cfg_data[1:0];
                imu_fs_pkg::CFG_TEMP_GAIN: r_gain      <= i_cfg_data[23:0];
                imu_fs_pkg::CFG_TEMP_BIAS: r_offset    <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Accumulate temperature until the burst limit, clear after the last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (i_cmd.mul) begin
            if (r_cnt < imu_fs_pkg::CNT_W'(imu_fs_pkg::MAX_FRAMES)) begin
                r_acc <= r_acc + imu_fs_pkg::ACC_W'(r_temp);
                r_cnt <= r_cnt + 1'b1;
            end
        end else if (i_cmd.tadj) begin
            r_acc <= '0;
            r_cnt <= '0;
        end
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ax   <= i_accel_x_raw;
            r_ay   <= i_accel_y_raw;
            r_az   <= i_accel_z_raw;
            r_temp <= i_temp_raw;
            r_gx   <= i_gyro_x_raw;
            r_gy   <= i_gyro_y_raw;
            r_gz   <= i_gyro_z_raw;
            r_last <= i_last_frame;
        end
        if (i_cmd.mul) begin
            for (int i = 0; i < 3; i++) begin
                r_amag[i] <= a_prod[i];
                r_aneg[i] <= a_val[i][15];
                r_gyro[i] <= {g_prod[i][26], g_prod[i]} << r_gyro_sel;
            end
        end
        if (i_cmd.rnd) begin
            for (int i = 0; i < 3; i++) begin
                r_aout[i] <= r_aneg[i] ? $signed(25'd0 - a_q[i]) : $signed(a_q[i]);
            end
            r_tneg  <= r_acc[imu_fs_pkg::ACC_W-1];
            r_tprod <= acc_mag * r_gain;
        end
        if (i_cmd.tadj) begin
            r_frames <= cnt_ext[7:0];
        end
        if (i_cmd.fin) begin
            r_temp_out <= t_sat[23:0];
        end
    end

    // Output register: hold while stalled, load when free
    assign out_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_ax     <= r_aout[0];
            r_o_ay     <= r_aout[1];
            r_o_az     <= r_aout[2];
            r_o_gx     <= r_gyro[0];
            r_o_gy     <= r_gyro[1];
            r_o_gz     <= r_gyro[2];
            r_o_temp   <= r_last ? r_temp_out : 24'sd0;
            r_o_tvalid <= r_last;
            r_o_frames <= r_last ? r_frames : 8'd0;
            r_o_last   <= r_last;
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = out_free;

    assign o_out_valid       = r_ovalid;
    assign o_accel_x_out     = r_o_ax;
    assign o_accel_y_out     = r_o_ay;
    assign o_accel_z_out     = r_o_az;
    assign o_gyro_x_out      = r_o_gx;
    assign o_gyro_y_out      = r_o_gy;
    assign o_gyro_z_out      = r_o_gz;
    assign o_temperature_out = r_o_temp;
    assign o_temp_valid      = r_o_tvalid;
    assign o_frames_in_burst = r_o_frames;
    assign o_last_out        = r_o_last;

endmodule

`default_nettype wire

// File: rtl/imu_fs_ctrl.sv
// Controller state machine sequencing capture, scaling, temperature average and output load.
`default_nettype none

module imu_fs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output imu_fs_pkg::t_cmd       o_cmd,
    input  wire imu_fs_pkg::t_sts  i_sts
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_RND  = 7'b0000100,
        S_TADJ = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_LOAD = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = i_sts.last ? S_TADJ : S_LOAD;
            end
            S_TADJ: begin
                o_cmd.tadj = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // An accepted word always moves on to the multiply step
    a_accept_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_MUL))
        else $error("accepted word did not enter multiply");

    // Division state is left only on divider done
    a_div_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_done) |=> (r_state == S_DIV))
        else $error("left divide state early");

    // A word that is not last skips the temperature average
    a_short_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RND && !i_sts.last) |=> (r_state == S_LOAD))
        else $error("non-last word took the divide path");

endmodule

`default_nettype wire

// File: rtl/imu_fifo_frame_scaler_top.sv
// Top level of the IMU frame scaler: controller, datapath and configuration port.
//
//  channel  direction  handshake                word
//  in       input      i_in_valid / o_in_stall  raw accel, temp, gyro words, last flag
//  out      output     o_out_valid / i_out_stall scaled axes, burst temperature, count
//  cfg      input      i_cfg_valid / o_cfg_ready register index and write data
//
// A word that is not last passes through capture, multiply, round and the load of the
// output register before the next word is accepted. A last word adds the temperature
// average between round and load: a setup step, one quotient bit per cycle of the
// restoring divider (40 bits at a 128-frame limit), a wait for the divider done and an
// offset step.
// Reset is synchronous and active low; it restores the register defaults and clears
// the burst sum and count. A stalled output holds its word; the next input word is
// taken while it waits, and its load waits until the output register frees.
`default_nettype none

module imu_fifo_frame_scaler_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_accel_x_raw,
    input  wire logic signed [15:0] i_accel_y_raw,
    input  wire logic signed [15:0] i_accel_z_raw,
    input  wire logic signed [15:0] i_temp_raw,
    input  wire logic signed [15:0] i_gyro_x_raw,
    input  wire logic signed [15:0] i_gyro_y_raw,
    input  wire logic signed [15:0] i_gyro_z_raw,
    input  wire logic               i_last_frame,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [24:0]      o_accel_x_out,
    output logic signed [24:0]      o_accel_y_out,
    output logic signed [24:0]      o_accel_z_out,
    output logic signed [27:0]      o_gyro_x_out,
    output logic signed [27:0]      o_gyro_y_out,
    output logic signed [27:0]      o_gyro_z_out,
    output logic signed [23:0]      o_temperature_out,
    output logic                    o_temp_valid,
    output logic [7:0]              o_frames_in_burst,
    output logic                    o_last_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [24:0]        i_cfg_data
);

    imu_fs_pkg::t_cmd cmd;
    imu_fs_pkg::t_sts sts;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    imu_fs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    imu_fs_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_accel_x_raw     (i_accel_x_raw),
        .i_accel_y_raw     (i_accel_y_raw),
        .i_accel_z_raw     (i_accel_z_raw),
        .i_temp_raw        (i_temp_raw),
        .i_gyro_x_raw      (i_gyro_x_raw),
        .i_gyro_y_raw      (i_gyro_y_raw),
        .i_gyro_z_raw      (i_gyro_z_raw),
        .i_last_frame      (i_last_frame),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_accel_x_out     (o_accel_x_out),
        .o_accel_y_out     (o_accel_y_out),
        .o_accel_z_out     (o_accel_z_out),
        .o_gyro_x_out      (o_gyro_x_out),
        .o_gyro_y_out      (o_gyro_y_out),
        .o_gyro_z_out      (o_gyro_z_out),
        .o_temperature_out (o_temperature_out),
        .o_temp_valid      (o_temp_valid),
        .o_frames_in_burst (o_frames_in_burst),
        .o_last_out        (o_last_out)
    );

endmodule

`default_nettype wire
